// ===== src/ufsg_pkg.sv =====
// Package for the UDP flow sweep slot generator: types, constants and register indexes.
// Used by every module of the block; depends on nothing.
package ufsg_pkg;

  localparam int unsigned MAX_FRAGS   = 64;
  localparam int unsigned FRAG_W      = 7;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INDIRECT = 2'd0,
    MODE_COPY     = 2'd1,
    MODE_MEMCPY   = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_PORT_MIN = 4'd0,
    REG_SRC_PORT_MAX = 4'd1,
    REG_SRC_IP_FIRST = 4'd2,
    REG_SRC_IP_LAST  = 4'd3,
    REG_DST_PORT_MIN = 4'd4,
    REG_DST_PORT_MAX = 4'd5,
    REG_DST_IP_FIRST = 4'd6,
    REG_DST_IP_LAST  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [15:0] slot_length;
    logic        more_fragments;
    logic        report;
    logic        indirect;
    logic        step;
  } slot_entry_t;

  typedef struct packed {
    logic              push;
    logic [FRAG_W-1:0] frags_left;
  } front_status_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

endpackage

// ===== src/udp_flow_sweep_slot_generator_core.sv =====
// Top level of the UDP flow sweep slot generator: front end, item queue and back end.
// Depends on ufsg_pkg, ufsg_front, ufsg_queue and ufsg_back.
//
//   channel  handshake             carries
//   in_      in_valid / in_stall   mode, fragment count, last-of-batch mark, packet size
//   out_     out_valid / out_stall addresses, ports, slot length and slot flags
//   cfg_     cfg_valid / cfg_ready register index and write data
//
// One item per cycle while out_stall is low; an item is queued, then registered at the output.
// The address counters step in the back end in the cycle an item leaves the queue.
// The four-entry queue lets the input keep accepting while the output is stalled, until it fills.
// Reset clears the registers, counters and fragment countdown; cfg_ready is always high.
module udp_flow_sweep_slot_generator_core
  import ufsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [FRAG_W-1:0]     in_frags_per_packet,
  input  logic                  in_last_of_batch,
  input  logic [15:0]           in_packet_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_src_ip_out,
  output logic [15:0]           out_src_port_out,
  output logic [31:0]           out_dst_ip_out,
  output logic [15:0]           out_dst_port_out,
  output logic [15:0]           out_slot_length,
  output logic                  out_more_fragments,
  output logic                  out_report,
  output logic                  out_indirect,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  slot_entry_t   front_entry;
  slot_entry_t   head;
  front_status_t front_status;
  queue_status_t queue_status;
  cfg_wr_t       cfg_wr;
  logic          pop;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  ufsg_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .queue_full          (queue_status.full),
    .in_mode             (in_mode),
    .in_frags_per_packet (in_frags_per_packet),
    .in_last_of_batch    (in_last_of_batch),
    .in_packet_size      (in_packet_size),
    .in_stall            (in_stall),
    .entry               (front_entry),
    .status              (front_status)
  );

  ufsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_status.push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (queue_status)
  );

  ufsg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr             (cfg_wr),
    .queue_empty        (queue_status.empty),
    .head               (head),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_src_ip_out     (out_src_ip_out),
    .out_src_port_out   (out_src_port_out),
    .out_dst_ip_out     (out_dst_ip_out),
    .out_dst_port_out   (out_dst_port_out),
    .out_slot_length    (out_slot_length),
    .out_more_fragments (out_more_fragments),
    .out_report         (out_report),
    .out_indirect       (out_indirect)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !queue_status.empty)
    else $error("pop from an empty queue");

  a_frags_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_status.frags_left < FRAG_W'(MAX_FRAGS))
    else $error("fragment countdown out of range");

  a_report_no_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report) |-> !out_more_fragments)
    else $error("more-fragments mark on the last slot of a batch");

endmodule

// ===== src/ufsg_front.sv =====
// Front end: accepts slot requests, runs the fragment countdown and classifies each item.
// Depends on ufsg_pkg.
module ufsg_front
  import ufsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              queue_full,
  input  logic [1:0]        in_mode,
  input  logic [FRAG_W-1:0] in_frags_per_packet,
  input  logic              in_last_of_batch,
  input  logic [15:0]       in_packet_size,
  output logic              in_stall,
  output slot_entry_t       entry,
  output front_status_t     status
);

  logic [FRAG_W-1:0] frags_left_r;
  logic [FRAG_W-1:0] frags_left_nxt;
  logic [FRAG_W-1:0] nf;
  logic [FRAG_W-1:0] fc;
  logic [FRAG_W-1:0] fc_dec;
  logic              accept;
  logic              first_frag;
  mode_t             mode;

  assign mode     = mode_t'(in_mode);
  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    if (in_frags_per_packet == '0) begin
      nf = FRAG_W'(1);
    end else if (in_frags_per_packet > FRAG_W'(MAX_FRAGS)) begin
      nf = FRAG_W'(MAX_FRAGS);
    end else begin
      nf = in_frags_per_packet;
    end
    if (frags_left_r == '0 || frags_left_r > nf) begin
      fc = nf;
    end else begin
      fc = frags_left_r;
    end
    first_frag     = (fc == nf);
    fc_dec         = fc - FRAG_W'(1);
    frags_left_nxt = in_last_of_batch ? '0 : fc_dec;
  end

  always_comb begin
    entry.slot_length    = in_packet_size;
    entry.more_fragments = (fc_dec != '0) && !in_last_of_batch;
    entry.report         = in_last_of_batch;
    entry.indirect       = (mode == MODE_INDIRECT);
    entry.step           = first_frag && (mode == MODE_COPY || mode == MODE_MEMCPY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frags_left_r <= '0;
    end else if (accept) begin
      frags_left_r <= frags_left_nxt;
    end
  end

  assign status.push       = accept;
  assign status.frags_left = frags_left_r;

endmodule

// ===== src/ufsg_queue.sv =====
// Short queue of classified slot items between the front end and the back end.
// Depends on ufsg_pkg.
module ufsg_queue
  import ufsg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  slot_entry_t   push_entry,
  input  logic          pop,
  output slot_entry_t   head,
  output queue_status_t status
);

  slot_entry_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign head          = mem_r[rd_ptr_r];
  assign status.full   = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty  = (count_r == '0);
  assign status.count  = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== src/ufsg_back.sv =====
// Back end: holds the sweep ranges and address counters, stamps each item and registers the result.
// Depends on ufsg_pkg.
module ufsg_back
  import ufsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg_wr,
  input  logic        queue_empty,
  input  slot_entry_t head,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [31:0] out_src_ip_out,
  output logic [15:0] out_src_port_out,
  output logic [31:0] out_dst_ip_out,
  output logic [15:0] out_dst_port_out,
  output logic [15:0] out_slot_length,
  output logic        out_more_fragments,
  output logic        out_report,
  output logic        out_indirect
);

  logic [15:0] src_port_min_r, src_port_max_r, dst_port_min_r, dst_port_max_r;
  logic [31:0] src_ip_first_r, src_ip_last_r, dst_ip_first_r, dst_ip_last_r;
  logic [15:0] src_port_min_nxt, src_port_max_nxt, dst_port_min_nxt, dst_port_max_nxt;
  logic [31:0] src_ip_first_nxt, src_ip_last_nxt, dst_ip_first_nxt, dst_ip_last_nxt;
  logic        cfg_hit;

  logic [15:0] cur_src_port_r, cur_dst_port_r, cur_src_port_nxt, cur_dst_port_nxt;
  logic [31:0] cur_src_ip_r, cur_dst_ip_r, cur_src_ip_nxt, cur_dst_ip_nxt;

  logic        out_valid_r;
  logic [31:0] src_ip_r, dst_ip_r;
  logic [15:0] src_port_r, dst_port_r, slot_length_r;
  logic        more_r, report_r, indirect_r;

  always_comb begin
    src_port_min_nxt = src_port_min_r;
    src_port_max_nxt = src_port_max_r;
    src_ip_first_nxt = src_ip_first_r;
    src_ip_last_nxt  = src_ip_last_r;
    dst_port_min_nxt = dst_port_min_r;
    dst_port_max_nxt = dst_port_max_r;
    dst_ip_first_nxt = dst_ip_first_r;
    dst_ip_last_nxt  = dst_ip_last_r;
    cfg_hit          = 1'b0;
    if (cfg_wr.valid) begin
      cfg_hit = 1'b1;
      unique case (cfg_wr.index)
        REG_SRC_PORT_MIN: src_port_min_nxt = cfg_wr.data[15:0];
        REG_SRC_PORT_MAX: src_port_max_nxt = cfg_wr.data[15:0];
        REG_SRC_IP_FIRST: src_ip_first_nxt = cfg_wr.data;
        REG_SRC_IP_LAST:  src_ip_last_nxt  = cfg_wr.data;
        REG_DST_PORT_MIN: dst_port_min_nxt = cfg_wr.data[15:0];
        REG_DST_PORT_MAX: dst_port_max_nxt = cfg_wr.data[15:0];
        REG_DST_IP_FIRST: dst_ip_first_nxt = cfg_wr.data;
        REG_DST_IP_LAST:  dst_ip_last_nxt  = cfg_wr.data;
        default:          cfg_hit          = 1'b0;
      endcase
    end
  end

  assign pop = !queue_empty && (!out_valid_r || !out_stall);

  // The counters step like an odometer: source port first, destination address last.
  always_comb begin
    cur_src_port_nxt = cur_src_port_r;
    cur_src_ip_nxt   = cur_src_ip_r;
    cur_dst_port_nxt = cur_dst_port_r;
    cur_dst_ip_nxt   = cur_dst_ip_r;
    if (cfg_hit) begin
      cur_src_port_nxt = src_port_min_nxt;
      cur_src_ip_nxt   = src_ip_first_nxt;
      cur_dst_port_nxt = dst_port_min_nxt;
      cur_dst_ip_nxt   = dst_ip_first_nxt;
    end else if (pop && head.step) begin
      priority if (cur_src_port_r < src_port_max_r) begin
        cur_src_port_nxt = cur_src_port_r + 16'd1;
      end else if (cur_src_ip_r < src_ip_last_r) begin
        cur_src_port_nxt = src_port_min_r;
        cur_src_ip_nxt   = cur_src_ip_r + 32'd1;
      end else if (cur_dst_port_r < dst_port_max_r) begin
        cur_src_port_nxt = src_port_min_r;
        cur_src_ip_nxt   = src_ip_first_r;
        cur_dst_port_nxt = cur_dst_port_r + 16'd1;
      end else if (cur_dst_ip_r < dst_ip_last_r) begin
        cur_src_port_nxt = src_port_min_r;
        cur_src_ip_nxt   = src_ip_first_r;
        cur_dst_port_nxt = dst_port_min_r;
        cur_dst_ip_nxt   = cur_dst_ip_r + 32'd1;
      end else begin
        cur_src_port_nxt = src_port_min_r;
        cur_src_ip_nxt   = src_ip_first_r;
        cur_dst_port_nxt = dst_port_min_r;
        cur_dst_ip_nxt   = dst_ip_first_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_port_min_r <= '0;
      src_port_max_r <= '0;
      src_ip_first_r <= '0;
      src_ip_last_r  <= '0;
      dst_port_min_r <= '0;
      dst_port_max_r <= '0;
      dst_ip_first_r <= '0;
      dst_ip_last_r  <= '0;
      cur_src_port_r <= '0;
      cur_src_ip_r   <= '0;
      cur_dst_port_r <= '0;
      cur_dst_ip_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      src_port_min_r <= src_port_min_nxt;
      src_port_max_r <= src_port_max_nxt;
      src_ip_first_r <= src_ip_first_nxt;
      src_ip_last_r  <= src_ip_last_nxt;
      dst_port_min_r <= dst_port_min_nxt;
      dst_port_max_r <= dst_port_max_nxt;
      dst_ip_first_r <= dst_ip_first_nxt;
      dst_ip_last_r  <= dst_ip_last_nxt;
      cur_src_port_r <= cur_src_port_nxt;
      cur_src_ip_r   <= cur_src_ip_nxt;
      cur_dst_port_r <= cur_dst_port_nxt;
      cur_dst_ip_r   <= cur_dst_ip_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      src_ip_r      <= cur_src_ip_r;
      src_port_r    <= cur_src_port_r;
      dst_ip_r      <= cur_dst_ip_r;
      dst_port_r    <= cur_dst_port_r;
      slot_length_r <= head.slot_length;
      more_r        <= head.more_fragments;
      report_r      <= head.report;
      indirect_r    <= head.indirect;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_src_ip_out     = src_ip_r;
  assign out_src_port_out   = src_port_r;
  assign out_dst_ip_out     = dst_ip_r;
  assign out_dst_port_out   = dst_port_r;
  assign out_slot_length    = slot_length_r;
  assign out_more_fragments = more_r;
  assign out_report         = report_r;
  assign out_indirect       = indirect_r;

endmodule

// ===== verif/udp_flow_sweep_slot_generator_core_tb.sv =====
// Self-checking testbench for the UDP flow sweep slot generator core: it predicts each slot's
// header addresses and flags and compares them with every result the block emits.
// Depends on ufsg_pkg and udp_flow_sweep_slot_generator_core.
module udp_flow_sweep_slot_generator_core_tb;
  import ufsg_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG = 4'd8;

  typedef struct {
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [31:0] dst_ip;
    logic [15:0] dport;
    logic [15:0] length;
    logic        more;
    logic        report;
    logic        indirect;
  } slot_hdr_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_mode;
  logic [FRAG_W-1:0]     in_frags_per_packet;
  logic                  in_last_of_batch;
  logic [15:0]           in_packet_size;
  logic                  out_valid;
  logic                  out_stall;
  logic [31:0]           out_src_ip_out;
  logic [15:0]           out_src_port_out;
  logic [31:0]           out_dst_ip_out;
  logic [15:0]           out_dst_port_out;
  logic [15:0]           out_slot_length;
  logic                  out_more_fragments;
  logic                  out_report;
  logic                  out_indirect;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [15:0]       rng_src_port_min = '0, rng_src_port_max = '0;
  logic [31:0]       rng_src_ip_first = '0, rng_src_ip_last = '0;
  logic [15:0]       rng_dst_port_min = '0, rng_dst_port_max = '0;
  logic [31:0]       rng_dst_ip_first = '0, rng_dst_ip_last = '0;
  logic [15:0]       sweep_src_port = '0, sweep_dst_port = '0;
  logic [31:0]       sweep_src_ip = '0, sweep_dst_ip = '0;
  logic [FRAG_W-1:0] frag_countdown = '0;

  slot_hdr_t expected_slots[$];
  bit        idle_on = 1'b1;
  bit        hold_request = 1'b0;
  int        error_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        reg_writes = 0;
  int        input_stall_cycles = 0;
  int        cycle_count = 0;

  udp_flow_sweep_slot_generator_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_frags_per_packet(in_frags_per_packet),
    .in_last_of_batch   (in_last_of_batch),
    .in_packet_size     (in_packet_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_src_ip_out     (out_src_ip_out),
    .out_src_port_out   (out_src_port_out),
    .out_dst_ip_out     (out_dst_ip_out),
    .out_dst_port_out   (out_dst_port_out),
    .out_slot_length    (out_slot_length),
    .out_more_fragments (out_more_fragments),
    .out_report         (out_report),
    .out_indirect       (out_indirect),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reload_sweep();
    sweep_src_port = rng_src_port_min;
    sweep_src_ip   = rng_src_ip_first;
    sweep_dst_port = rng_dst_port_min;
    sweep_dst_ip   = rng_dst_ip_first;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_SRC_PORT_MIN: rng_src_port_min = data[15:0];
      REG_SRC_PORT_MAX: rng_src_port_max = data[15:0];
      REG_SRC_IP_FIRST: rng_src_ip_first = data;
      REG_SRC_IP_LAST:  rng_src_ip_last  = data;
      REG_DST_PORT_MIN: rng_dst_port_min = data[15:0];
      REG_DST_PORT_MAX: rng_dst_port_max = data[15:0];
      REG_DST_IP_FIRST: rng_dst_ip_first = data;
      REG_DST_IP_LAST:  rng_dst_ip_last  = data;
      default: return;
    endcase
    reload_sweep();
  endfunction

  function automatic void step_odometer();
    if (sweep_src_port < rng_src_port_max) begin
      sweep_src_port++;
      return;
    end
    sweep_src_port = rng_src_port_min;
    if (sweep_src_ip < rng_src_ip_last) begin
      sweep_src_ip++;
      return;
    end
    sweep_src_ip = rng_src_ip_first;
    if (sweep_dst_port < rng_dst_port_max) begin
      sweep_dst_port++;
      return;
    end
    sweep_dst_port = rng_dst_port_min;
    if (sweep_dst_ip < rng_dst_ip_last) begin
      sweep_dst_ip++;
      return;
    end
    sweep_dst_ip = rng_dst_ip_first;
  endfunction

  function automatic slot_hdr_t predict_slot(input mode_t mode, input logic [FRAG_W-1:0] frags,
                                             input logic last, input logic [15:0] size);
    slot_hdr_t r;
    int nf;
    int fc;
    nf = (frags == 0) ? 1 : ((frags > MAX_FRAGS) ? MAX_FRAGS : frags);
    fc = frag_countdown;
    if (fc == 0 || fc > nf) fc = nf;
    r.src_ip   = sweep_src_ip;
    r.sport    = sweep_src_port;
    r.dst_ip   = sweep_dst_ip;
    r.dport    = sweep_dst_port;
    r.length   = size;
    if ((mode == MODE_COPY || mode == MODE_MEMCPY) && fc == nf) step_odometer();
    fc--;
    r.more     = (fc > 0) && !last;
    r.report   = last;
    r.indirect = (mode == MODE_INDIRECT);
    frag_countdown = last ? '0 : fc[FRAG_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR at result %0d: %s", results_checked, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    slot_hdr_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      results_checked++;
      if (expected_slots.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = expected_slots.pop_front();
        check_field("src_ip", out_src_ip_out, want.src_ip);
        check_field("source port", {16'd0, out_src_port_out}, {16'd0, want.sport});
        check_field("dst_ip", out_dst_ip_out, want.dst_ip);
        check_field("destination port", {16'd0, out_dst_port_out}, {16'd0, want.dport});
        check_field("slot_length", {16'd0, out_slot_length}, {16'd0, want.length});
        check_field("more_fragments", {31'd0, out_more_fragments}, {31'd0, want.more});
        check_field("report", {31'd0, out_report}, {31'd0, want.report});
        check_field("indirect", {31'd0, out_indirect}, {31'd0, want.indirect});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_valid === 1'b1 && in_stall === 1'b1) input_stall_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("udp_flow_sweep_slot_generator_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_stall <= idle_on && ($urandom_range(99) < 29);
    end
  end

  task automatic send_slot(input mode_t mode, input logic [FRAG_W-1:0] frags,
                           input logic last, input logic [15:0] size);
    if (idle_on) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_frags_per_packet <= frags;
    in_last_of_batch    <= last;
    in_packet_size      <= size;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_slots.push_back(predict_slot(mode, frags, last, size));
    items_sent++;
  endtask

  task automatic send_random_slot();
    mode_t             mode;
    logic [FRAG_W-1:0] frags;
    int                pick;
    pick = $urandom_range(9);
    if (pick < 6) mode = ($urandom_range(1) == 0) ? MODE_COPY : MODE_MEMCPY;
    else mode = mode_t'($urandom_range(3));
    pick = $urandom_range(19);
    if (pick < 15) frags = FRAG_W'($urandom_range(1, 4));
    else if (pick < 18) frags = FRAG_W'($urandom_range(5, MAX_FRAGS));
    else frags = FRAG_W'($urandom_range(0, 127));
    send_slot(mode, frags, $urandom_range(7) == 0, 16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic program_sweep(input logic [31:0] sp_min, input logic [31:0] sp_max,
                               input logic [31:0] sip_first, input logic [31:0] sip_last,
                               input logic [31:0] dp_min, input logic [31:0] dp_max,
                               input logic [31:0] dip_first, input logic [31:0] dip_last);
    write_reg(REG_SRC_PORT_MIN, sp_min);
    write_reg(REG_SRC_PORT_MAX, sp_max);
    write_reg(REG_SRC_IP_FIRST, sip_first);
    write_reg(REG_SRC_IP_LAST, sip_last);
    write_reg(REG_DST_PORT_MIN, dp_min);
    write_reg(REG_DST_PORT_MAX, dp_max);
    write_reg(REG_DST_IP_FIRST, dip_first);
    write_reg(REG_DST_IP_LAST, dip_last);
  endtask

  task automatic test_reset_state();
    send_slot(MODE_COPY, 7'd1, 1'b0, 16'd60);
    send_slot(MODE_MEMCPY, 7'd1, 1'b0, 16'd61);
    send_slot(MODE_INDIRECT, 7'd1, 1'b0, 16'd62);
    send_slot(MODE_NONE, 7'd1, 1'b1, 16'd63);
    send_slot(MODE_COPY, 7'd2, 1'b0, 16'd64);
    send_slot(MODE_COPY, 7'd2, 1'b0, 16'd65);
    wait_idle();
  endtask

  task automatic test_directed_fields();
    program_sweep(32'd1000, 32'd1002, 32'h0A00_0001, 32'h0A00_0002,
                  32'd53, 32'd54, 32'hC0A8_0001, 32'hC0A8_0001);
    send_slot(MODE_COPY, 7'd1, 1'b0, 16'h0000);
    send_slot(MODE_MEMCPY, 7'd1, 1'b0, 16'hFFFF);
    send_slot(MODE_INDIRECT, 7'd1, 1'b0, 16'd64);
    send_slot(MODE_NONE, 7'd1, 1'b0, 16'd1500);
    // A fragment count of zero behaves as a single-fragment packet.
    send_slot(MODE_COPY, 7'd0, 1'b0, 16'd100);
    repeat (3) send_slot(MODE_COPY, 7'd3, 1'b0, 16'h5555);
    // An oversized count saturates; a smaller count below the fragments left restarts the packet.
    send_slot(MODE_COPY, 7'd127, 1'b0, 16'hAAAA);
    send_slot(MODE_COPY, 7'd5, 1'b0, 16'd200);
    send_slot(MODE_COPY, 7'd2, 1'b0, 16'd201);
    send_slot(MODE_COPY, 7'd2, 1'b0, 16'd202);
    // The last slot of a batch in the middle of a packet ends it early.
    send_slot(MODE_MEMCPY, 7'd4, 1'b0, 16'd300);
    send_slot(MODE_MEMCPY, 7'd4, 1'b1, 16'd301);
    send_slot(MODE_MEMCPY, 7'd4, 1'b0, 16'd302);
    repeat (2) send_slot(MODE_INDIRECT, 7'd2, 1'b0, 16'd400);
    send_slot(MODE_NONE, 7'd64, 1'b1, 16'd401);
    send_slot(MODE_MEMCPY, 7'd65, 1'b0, 16'd402);
    send_slot(MODE_COPY, 7'd64, 1'b1, 16'd403);
    send_slot(MODE_COPY, 7'd1, 1'b1, 16'd404);
    wait_idle();
  endtask

  task automatic test_range_extremes();
    // Upper bits of the port writes are not part of the register.
    program_sweep(32'hABCD_FFFE, 32'h0000_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                  32'h1234_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    repeat (12) send_slot(MODE_COPY, 7'd1, $urandom_range(3) == 0,
                          16'($urandom_range(0, 65535)));
    wait_idle();
    // A write outside the register map must leave the sweep where it is.
    write_reg(UNMAPPED_REG, $urandom);
    repeat (6) send_slot(MODE_MEMCPY, 7'd1, 1'b0, 16'($urandom_range(0, 65535)));
    wait_idle();
    program_sweep('1, '1, '1, '1, '1, '1, '1, '1);
    repeat (8) send_slot(MODE_COPY, 7'd1, 1'b0, 16'($urandom_range(0, 65535)));
    wait_idle();
  endtask

  task automatic test_random_sweeps();
    logic [31:0] sp0, sip0, dp0, dip0;
    for (int phase = 0; phase < 4; phase++) begin
      sp0  = $urandom;
      sip0 = $urandom;
      dp0  = $urandom;
      dip0 = $urandom;
      program_sweep(sp0, {16'($urandom_range(0, 65535)),
                          16'(sp0[15:0] + $urandom_range(0, 4) - 1)},
                    sip0, sip0 + $urandom_range(0, 4) - 1,
                    dp0, {16'($urandom_range(0, 65535)),
                          16'(dp0[15:0] + $urandom_range(0, 4) - 1)},
                    dip0, dip0 + $urandom_range(0, 4) - 1);
      repeat (110) send_random_slot();
      wait_idle();
    end
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    repeat (100) send_random_slot();
    idle_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_random_slot();
    idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_mode             <= MODE_INDIRECT;
    in_frags_per_packet <= '0;
    in_last_of_batch    <= 1'b0;
    in_packet_size      <= '0;
    cfg_valid           <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_fields();
    test_range_extremes();
    test_random_sweeps();
    test_no_idle_stretch();
    test_output_hold();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d slot items across %0d register writes; checked %0d results.",
             items_sent, reg_writes, results_checked);
    $display("The input was held back for %0d cycles while the output stalled.",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("udp_flow_sweep_slot_generator_core_tb OK");
    end else begin
      $display("udp_flow_sweep_slot_generator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== udp_flow_sweep_slot_generator_core.f =====
src/ufsg_pkg.sv
src/ufsg_front.sv
src/ufsg_queue.sv
src/ufsg_back.sv
src/udp_flow_sweep_slot_generator_core.sv
verif/udp_flow_sweep_slot_generator_core_tb.sv
